### src/rtw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtw_pkg
// Shared types and constants for the RGB to white / purity / hue converter.
// ----------------------------------------------------------------------------
package rtw_pkg;

	localparam int HUE_FRAC_BITS_DEF = 8;
	localparam int CHAN_W            = 8;
	localparam int HUE_W             = 10;

	localparam logic [1:0] PRIM_RED   = 2'd0;
	localparam logic [1:0] PRIM_GREEN = 2'd1;
	localparam logic [1:0] PRIM_BLUE  = 2'd2;

	// how the hue fraction is formed at the end of the pipe
	typedef enum logic [1:0] {
		HUE_FIXED,   // fraction zero
		HUE_DOWN,    // one - ceil(half * below / above)
		HUE_UP       // floor(half * above / below)
	} hue_kind_t;

	// fields that ride alongside the divider
	typedef struct packed {
		logic [CHAN_W-1:0] white;
		logic [CHAN_W-1:0] purity;
		logic [1:0]        primary;
		hue_kind_t         kind;
	} side_t;

endpackage

### src/rtw_minsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtw_minsub
// First stage: white level as the least channel, and white removal.
// ----------------------------------------------------------------------------
module rtw_minsub
	import rtw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	output logic              vld_s1,
	output logic [CHAN_W-1:0] white_s1,
	output logic [CHAN_W-1:0] rr_s1,
	output logic [CHAN_W-1:0] gg_s1,
	output logic [CHAN_W-1:0] bb_s1
);

	logic [CHAN_W-1:0] rg_min;
	logic [CHAN_W-1:0] w_min;

	always_comb begin
		rg_min = (green < red) ? green : red;
		w_min  = (blue < rg_min) ? blue : rg_min;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld) begin
			white_s1 <= w_min;
			rr_s1    <= red - w_min;
			gg_s1    <= green - w_min;
			bb_s1    <= blue - w_min;
		end
	end

endmodule

### src/rtw_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtw_classify
// Second stage: purity, hue primary and the dividend / divisor pair.
// ----------------------------------------------------------------------------
module rtw_classify
	import rtw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld,
	input  logic [CHAN_W-1:0] white,
	input  logic [CHAN_W-1:0] rr,
	input  logic [CHAN_W-1:0] gg,
	input  logic [CHAN_W-1:0] bb,
	output logic              vld_s2,
	output side_t             side_s2,
	output logic [CHAN_W-1:0] num_s2,
	output logic [CHAN_W-1:0] den_s2
);

	logic [CHAN_W-1:0] rg_max;
	logic [CHAN_W-1:0] below;
	logic [CHAN_W-1:0] above;
	logic [1:0]        nz_cnt;
	side_t             side_d;
	logic [CHAN_W-1:0] num_d;
	logic [CHAN_W-1:0] den_d;

	always_comb begin
		rg_max = (gg > rr) ? gg : rr;
		nz_cnt = 2'((rr != '0)) + 2'((gg != '0)) + 2'((bb != '0));

		side_d.white  = white;
		side_d.purity = (bb > rg_max) ? bb : rg_max;
		side_d.kind   = HUE_FIXED;
		side_d.primary = PRIM_GREEN;
		below = rr;
		above = gg;
		num_d = '0;
		den_d = CHAN_W'(1);

		case (nz_cnt)
			2'd0: begin
				side_d.primary = PRIM_GREEN;   // gray falls through to green
			end
			2'd1: begin
				if (rr != '0)
					side_d.primary = PRIM_RED;
				else if (gg != '0)
					side_d.primary = PRIM_GREEN;
				else
					side_d.primary = PRIM_BLUE;
			end
			default: begin
				if (bb == '0) begin
					side_d.primary = PRIM_RED;
					below = rr;
					above = gg;
				end else if (gg == '0) begin
					side_d.primary = PRIM_BLUE;
					below = bb;
					above = rr;
				end else begin
					side_d.primary = PRIM_GREEN;
					below = gg;
					above = bb;
				end
				// dividend never exceeds divisor
				if (above > below) begin
					side_d.kind = HUE_DOWN;
					num_d = below;
					den_d = above;
				end else begin
					side_d.kind = HUE_UP;
					num_d = above;
					den_d = below;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld) begin
			side_s2 <= side_d;
			num_s2  <= num_d;
			den_s2  <= den_d;
		end
	end

endmodule

### src/rtw_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtw_div_step
// One restoring division stage: one quotient bit per stage.
// ----------------------------------------------------------------------------
module rtw_div_step
	import rtw_pkg::*;
#(
	parameter int FRAC_BITS = HUE_FRAC_BITS_DEF,
	parameter bit SHIFT     = 1'b1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld,
	input  side_t                side,
	input  logic [CHAN_W-1:0]    rem,
	input  logic [CHAN_W-1:0]    den,
	input  logic [FRAC_BITS-1:0] quo,
	output logic                 vld_s,
	output side_t                side_s,
	output logic [CHAN_W-1:0]    rem_s,
	output logic [CHAN_W-1:0]    den_s,
	output logic [FRAC_BITS-1:0] quo_s
);

	logic [CHAN_W:0]   trial;
	logic [CHAN_W:0]   diff;
	logic              qbit;
	logic [CHAN_W-1:0] rem_d;

	// integer bit stage takes the remainder unshifted
	always_comb begin
		trial = SHIFT ? {rem, 1'b0} : {1'b0, rem};
		diff  = trial - {1'b0, den};
		qbit  = (trial >= {1'b0, den});
		rem_d = qbit ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (en) begin
			vld_s <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld) begin
			side_s <= side;
			rem_s  <= rem_d;
			den_s  <= den;
			quo_s  <= {quo[FRAC_BITS-2:0], qbit};
		end
	end

endmodule

### src/rtw_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtw_post
// Last stage: rounding of the quotient and assembly of the hue word.
// ----------------------------------------------------------------------------
module rtw_post
	import rtw_pkg::*;
#(
	parameter int FRAC_BITS = HUE_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld,
	input  side_t                side,
	input  logic [CHAN_W-1:0]    rem,
	input  logic [FRAC_BITS-1:0] quo,
	output logic                 vld_s,
	output logic [CHAN_W-1:0]    white_s,
	output logic [CHAN_W-1:0]    purity_s,
	output logic [HUE_W-1:0]     hue_s
);

	localparam int HW = (FRAC_BITS + 2 > HUE_W) ? FRAC_BITS + 2 : HUE_W;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [FRAC_BITS:0]   q_ceil;
	logic [FRAC_BITS:0]   frac;
	logic [FRAC_BITS+1:0] hue_f;
	logic [HW-1:0]        hue_x;

	always_comb begin
		q_ceil = {1'b0, quo} + (FRAC_BITS+1)'(rem != '0);
		case (side.kind)
			HUE_DOWN: frac = ONE - q_ceil;
			HUE_UP:   frac = {1'b0, quo};
			default:  frac = '0;
		endcase
		hue_f = {side.primary, frac[FRAC_BITS-1:0]};
		hue_x = HW'(hue_f);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (en) begin
			vld_s <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld) begin
			white_s  <= side.white;
			purity_s <= side.purity;
			hue_s    <= hue_x[HUE_W-1:0];
		end
	end

endmodule

### src/rgb_to_whp_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_whp_convert
// RGB pixel to white level, purity level and hue, fully pipelined.
// Stages: white removal, classification, one per divider bit, then hue assembly.
// Throughput: one beat per cycle; a held output beat stalls only the stages
// behind it that are full, bubbles are squeezed out.
// Reset clears all stage valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_whp_convert
	import rtw_pkg::*;
#(
	parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_stall,
	input  logic [CHAN_W-1:0] red,
	input  logic [CHAN_W-1:0] green,
	input  logic [CHAN_W-1:0] blue,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [CHAN_W-1:0] white_level,
	output logic [CHAN_W-1:0] purity_level,
	output logic [HUE_W-1:0]  hue_value
);

	localparam int F   = HUE_FRAC_BITS;
	localparam int NST = F + 3;

	logic                 vld [NST];
	logic                 en  [NST];

	logic [CHAN_W-1:0]    white_s1;
	logic [CHAN_W-1:0]    rr_s1;
	logic [CHAN_W-1:0]    gg_s1;
	logic [CHAN_W-1:0]    bb_s1;

	side_t                side_a [F+1];
	logic [CHAN_W-1:0]    rem_a  [F+1];
	logic [CHAN_W-1:0]    den_a  [F+1];
	logic [F-1:0]         quo_a  [F+1];

	// a stage may load when empty or when the one ahead moves
	genvar k;
	generate
		for (k = 0; k < NST - 1; k++) begin : g_en
			assign en[k] = !vld[k] || en[k+1];
		end
	endgenerate
	assign en[NST-1] = !vld[NST-1] || !res_stall;

	assign pix_stall = !en[0];
	assign res_valid = vld[NST-1];
	assign quo_a[0]  = '0;

	rtw_minsub u_minsub (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en[0]),
		.vld      (pix_valid),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.vld_s1   (vld[0]),
		.white_s1 (white_s1),
		.rr_s1    (rr_s1),
		.gg_s1    (gg_s1),
		.bb_s1    (bb_s1)
	);

	rtw_classify u_classify (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en[1]),
		.vld     (vld[0]),
		.white   (white_s1),
		.rr      (rr_s1),
		.gg      (gg_s1),
		.bb      (bb_s1),
		.vld_s2  (vld[1]),
		.side_s2 (side_a[0]),
		.num_s2  (rem_a[0]),
		.den_s2  (den_a[0])
	);

	generate
		for (k = 0; k < F; k++) begin : g_div
			rtw_div_step #(
				.FRAC_BITS (F),
				.SHIFT     (k != 0)
			) u_step (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en[k+2]),
				.vld    (vld[k+1]),
				.side   (side_a[k]),
				.rem    (rem_a[k]),
				.den    (den_a[k]),
				.quo    (quo_a[k]),
				.vld_s  (vld[k+2]),
				.side_s (side_a[k+1]),
				.rem_s  (rem_a[k+1]),
				.den_s  (den_a[k+1]),
				.quo_s  (quo_a[k+1])
			);
		end
	endgenerate

	rtw_post #(
		.FRAC_BITS (F)
	) u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en[NST-1]),
		.vld      (vld[NST-2]),
		.side     (side_a[F]),
		.rem      (rem_a[F]),
		.quo      (quo_a[F]),
		.vld_s    (vld[NST-1]),
		.white_s  (white_level),
		.purity_s (purity_level),
		.hue_s    (hue_value)
	);

endmodule

### sim/tb_rgb_to_whp_convert.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_whp_convert
// Self-checking bench for the RGB to white / purity / hue converter. A table
// of directed pixels (grey, primaries, secondaries, equal pairs, near-edge
// ratios) is followed by random pixels biased towards grey, single-primary
// and equal-pair shapes, also near-equal pairs and rails. Every result beat
// is compared in order against the table or a local predictor, under random
// idling on both channels, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb_rgb_to_whp_convert
	import rtw_pkg::*;
();

	localparam int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF;
	localparam int unsigned HUE_ONE  = 1 << HUE_FRAC_BITS;
	localparam int unsigned HUE_HALF = 1 << (HUE_FRAC_BITS - 1);
	localparam int unsigned HUE_MASK = (1 << HUE_W) - 1;
	localparam int N_DIRECTED   = 21;
	localparam int N_RANDOM     = 430;
	localparam int IDLE_PCT     = 21;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 4 * (HUE_FRAC_BITS + 3);
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [CHAN_W-1:0] white;
		logic [CHAN_W-1:0] purity;
		logic [HUE_W-1:0]  hue;
	} whp_t;

	// typed = 1: the expected fields are given here, else the predictor decides
	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic              typed;
		logic [CHAN_W-1:0] w;
		logic [CHAN_W-1:0] p;
		logic [HUE_W-1:0]  h;
	} pix_case_t;

	localparam pix_case_t DIRECTED_TAB [0:N_DIRECTED-1] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   10'd256},
		'{8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   10'd256},
		'{8'd128, 8'd128, 8'd128, 1'b1, 8'd128, 8'd0,   10'd256},
		'{8'd255, 8'd0,   8'd0,   1'b1, 8'd0,   8'd255, 10'd0},
		'{8'd0,   8'd255, 8'd0,   1'b1, 8'd0,   8'd255, 10'd256},
		'{8'd0,   8'd0,   8'd255, 1'b1, 8'd0,   8'd255, 10'd512},
		'{8'd255, 8'd255, 8'd0,   1'b1, 8'd0,   8'd255, 10'd128},
		'{8'd0,   8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 10'd384},
		'{8'd255, 8'd0,   8'd255, 1'b1, 8'd0,   8'd255, 10'd640},
		'{8'd10,  8'd200, 8'd200, 1'b1, 8'd10,  8'd190, 10'd384},
		'{8'd200, 8'd100, 8'd0,   1'b0, 8'd0,   8'd0,   10'd0},
		'{8'd100, 8'd200, 8'd0,   1'b0, 8'd0,   8'd0,   10'd0},
		'{8'd1,   8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   10'd0},
		'{8'd255, 8'd1,   8'd0,   1'b0, 8'd0,   8'd0,   10'd0},
		'{8'd0,   8'd1,   8'd255, 1'b0, 8'd0,   8'd0,   10'd0},
		'{8'd0,   8'd255, 8'd1,   1'b0, 8'd0,   8'd0,   10'd0},
		'{8'd255, 8'd0,   8'd1,   1'b0, 8'd0,   8'd0,   10'd0},
		'{8'd1,   8'd0,   8'd255, 1'b0, 8'd0,   8'd0,   10'd0},
		'{8'd37,  8'd91,  8'd203, 1'b0, 8'd0,   8'd0,   10'd0},
		'{8'd254, 8'd253, 8'd1,   1'b0, 8'd0,   8'd0,   10'd0},
		'{8'd170, 8'd85,  8'd255, 1'b0, 8'd0,   8'd0,   10'd0}
	};

	logic              clk;
	logic              arst_n;
	logic              pix_valid;
	logic              pix_stall;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic              res_valid;
	logic              res_stall;
	logic [CHAN_W-1:0] white_level;
	logic [CHAN_W-1:0] purity_level;
	logic [HUE_W-1:0]  hue_value;

	whp_t pending_whp[$];
	int   errors;
	bit   calm;       // no idling on either side
	bit   hold_req;   // ask the receiver for one long hold-off
	int   hold_left;

	rgb_to_whp_convert #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.white_level (white_level),
		.purity_level(purity_level),
		.hue_value   (hue_value)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#500000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int unsigned hue_fraction(input int unsigned below,
			input int unsigned above);
		if (above > below)
			return HUE_ONE - (HUE_HALF * below + above - 1) / above;
		if (below == 0)
			return 0;
		return (HUE_HALF * above) / below;
	endfunction

	function automatic whp_t predict_whp(input logic [CHAN_W-1:0] r,
			input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
		int unsigned rr, gg, bb, w, p, nz, hue;
		whp_t res;
		rr = 32'(r);
		gg = 32'(g);
		bb = 32'(b);
		w = rr;
		if (gg < w) w = gg;
		if (bb < w) w = bb;
		rr -= w;
		gg -= w;
		bb -= w;
		p = rr;
		if (gg > p) p = gg;
		if (bb > p) p = bb;
		nz = 32'(rr != 0) + 32'(gg != 0) + 32'(bb != 0);
		if (nz == 0)
			hue = 32'(PRIM_GREEN) * HUE_ONE;   // grey falls through to green
		else if (nz == 1) begin
			if (rr != 0)
				hue = 32'(PRIM_RED) * HUE_ONE;
			else if (gg != 0)
				hue = 32'(PRIM_GREEN) * HUE_ONE;
			else
				hue = 32'(PRIM_BLUE) * HUE_ONE;
		end else if (bb == 0)
			hue = 32'(PRIM_RED) * HUE_ONE + hue_fraction(rr, gg);
		else if (gg == 0)
			hue = 32'(PRIM_BLUE) * HUE_ONE + hue_fraction(bb, rr);
		else
			hue = 32'(PRIM_GREEN) * HUE_ONE + hue_fraction(gg, bb);
		res.white  = w[CHAN_W-1:0];
		res.purity = p[CHAN_W-1:0];
		res.hue    = HUE_W'(hue & HUE_MASK);
		return res;
	endfunction

	// one pixel beat; the expectation is queued at the accepting edge
	task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
			input logic [CHAN_W-1:0] b, input whp_t want);
		@(negedge clk);
		pix_valid <= 1'b1;
		red       <= r;
		green     <= g;
		blue      <= b;
		do
			@(posedge clk);
		while (pix_stall !== 1'b0);
		pending_whp.push_back(want);
		if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			@(negedge clk);
			pix_valid <= 1'b0;
			while ($urandom_range(0, 99) < IDLE_PCT)
				@(negedge clk);
		end
	endtask

	task automatic pick_pixel(output logic [CHAN_W-1:0] r, output logic [CHAN_W-1:0] g,
			output logic [CHAN_W-1:0] b);
		logic [CHAN_W-1:0] ch [3];
		int unsigned lo, hi, sel;
		lo  = $urandom_range(0, 254);
		hi  = $urandom_range(lo + 1, 255);
		sel = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++)
			ch[i] = CHAN_W'($urandom_range(0, 255));
		case ($urandom_range(0, 6))
			0: for (int i = 0; i < 3; i++) ch[i] = CHAN_W'(lo);   // grey
			1: begin                                              // single primary
				for (int i = 0; i < 3; i++) ch[i] = CHAN_W'(lo);
				ch[sel] = CHAN_W'(hi);
			end
			2: begin                                              // equal pair
				for (int i = 0; i < 3; i++) ch[i] = CHAN_W'(hi);
				ch[sel] = CHAN_W'(lo);
			end
			3: begin                                              // near-equal pair
				for (int i = 0; i < 3; i++) ch[i] = CHAN_W'(hi);
				ch[(sel + 1) % 3] = CHAN_W'(hi - 1);
				ch[sel] = CHAN_W'($urandom_range(0, hi - 1));
			end
			4: for (int i = 0; i < 3; i++)                        // rails
				case ($urandom_range(0, 2))
					0: ch[i] = '0;
					1: ch[i] = '1;
					default: ;
				endcase
			default: ;
		endcase
		r = ch[0];
		g = ch[1];
		b = ch[2];
	endtask

	initial begin
		logic [CHAN_W-1:0] r, g, b;
		whp_t want;
		arst_n    = 1'b0;
		pix_valid = 1'b0;
		red       = '0;
		green     = '0;
		blue      = '0;
		calm      = 1'b0;
		hold_req  = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED_TAB[i].typed)
				want = '{DIRECTED_TAB[i].w, DIRECTED_TAB[i].p, DIRECTED_TAB[i].h};
			else
				want = predict_whp(DIRECTED_TAB[i].r, DIRECTED_TAB[i].g, DIRECTED_TAB[i].b);
			send_pixel(DIRECTED_TAB[i].r, DIRECTED_TAB[i].g, DIRECTED_TAB[i].b, want);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 120) begin
				// sender pause until the pipe has drained
				@(negedge clk);
				pix_valid <= 1'b0;
				while (pending_whp.size() != 0)
					@(posedge clk);
			end
			calm = (i >= 200 && i < 300);
			if (i == 230)
				hold_req = 1'b1;   // back-pressure while beats keep coming
			pick_pixel(r, g, b);
			send_pixel(r, g, b, predict_whp(r, g, b));
		end

		@(negedge clk);
		pix_valid <= 1'b0;
		while (pending_whp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_whp.size() != 0)
			errors++;
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// receiver side
	initial begin
		res_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else
				res_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	initial errors = 0;

	always @(posedge clk) begin
		whp_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (pending_whp.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result beat: w=%0d p=%0d h=%0d",
						white_level, purity_level, hue_value);
			end else begin
				want = pending_whp.pop_front();
				if (white_level !== want.white || purity_level !== want.purity ||
						hue_value !== want.hue) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("mismatch: exp w=%0d p=%0d h=%0d, got w=%0d p=%0d h=%0d",
							want.white, want.purity, want.hue,
							white_level, purity_level, hue_value);
				end
			end
		end
	end

endmodule

### rgb_to_whp_convert.f
src/rtw_pkg.sv
src/rtw_minsub.sv
src/rtw_classify.sv
src/rtw_div_step.sv
src/rtw_post.sv
src/rgb_to_whp_convert.sv
sim/tb_rgb_to_whp_convert.sv
